// ----- hdl/elt_pkg.sv -----
// Package for the event table timestamp matcher.
// Holds the controller state type, request, result and status codes, config indices and limits.
// No dependencies.
package elt_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WIN,
		S_SUM,
		S_RD,
		S_CHK,
		S_MATCH,
		S_DIV,
		S_PUSH,
		S_END
	} state_t;

	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_WINDOW = 2'd1;
	localparam logic [1:0] REQ_EVENT  = 2'd2;
	localparam logic [1:0] REQ_SPARE  = 2'd3;

	localparam logic [1:0] KIND_WINDOW  = 2'd0;
	localparam logic [1:0] KIND_MATCH   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_LATE  = 2'd1;
	localparam logic [1:0] ST_EARLY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic CFG_DEAD_BAND = 1'b0;
	localparam logic CFG_END_CODE  = 1'b1;

	localparam int OUT_LIMIT = 64;
	localparam logic [20:0] IDX_MAX = 21'h0FFFFF;
	localparam logic [6:0] COUNT_MAX = 7'd127;

endpackage

// ----- hdl/elt_scale.sv -----
// Sample index scaler: floor(a * b / c) for b <= c, one bit of a, top bit first, per shift and add phase.
// Restoring shift-add/subtract over a 65-bit remainder. Uses elt_pkg.
module elt_scale (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [20:0] a,
	input  logic [63:0] b,
	input  logic [63:0] c,
	output logic        done,
	output logic [20:0] q
);
	import elt_pkg::*;

	logic [20:0] a_q;
	logic [63:0] b_q;
	logic [63:0] c_q;
	logic [64:0] r_q;
	logic [20:0] q_q;
	logic [4:0]  k_q;
	logic        phase_q;
	logic        run_q;
	logic        done_q;

	logic [64:0] sel;
	logic        ge;
	logic [64:0] r_nx;
	logic [20:0] q_nx;

	always_comb begin
		if (!phase_q) begin
			sel = {r_q[63:0], 1'b0};
		end else if (a_q[k_q]) begin
			sel = r_q + {1'b0, b_q};
		end else begin
			sel = r_q;
		end
		ge = (sel >= {1'b0, c_q});
		r_nx = ge ? (sel - {1'b0, c_q}) : sel;
		q_nx = phase_q ? (q_q + {20'd0, ge}) : {q_q[19:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			k_q     <= 5'd0;
			r_q     <= '0;
			q_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
		end else begin
			done_q <= run_q && phase_q && (k_q == 5'd0);
			if (start) begin
				a_q     <= a;
				b_q     <= b;
				c_q     <= c;
				r_q     <= '0;
				q_q     <= '0;
				k_q     <= 5'd20;
				phase_q <= 1'b0;
				run_q   <= 1'b1;
			end else if (run_q) begin
				r_q     <= r_nx;
				q_q     <= q_nx;
				phase_q <= !phase_q;
				if (phase_q) begin
					if (k_q == 5'd0) begin
						run_q <= 1'b0;
					end else begin
						k_q <= k_q - 5'd1;
					end
				end
			end
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

// ----- hdl/event_lut_timestamp_match.sv -----
// Top level of the event table timestamp matcher: table memory, scan controller,
// window check and result register. Uses elt_pkg and elt_scale.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_we                cfg_index, cfg_data
//   in       in         in_valid / in_ready   req_type .. samples_in_buffer
//   out      out        out_valid / out_ready result_kind .. last
//
// Table writes finish in S_IDLE; window and summary beats use S_WIN and S_SUM.
// An event row reads the table entries in order through S_RD and S_CHK; each
// match is checked in S_MATCH and dropped if out of buffer or full, else scaled
// by the index scaler in S_DIV unless the window is flat, then queued in S_PUSH.
// Reset clears all control state; the table holds no valid bits.
// One item at a time; a stalled result holds the next result beat or the end of a row.
module event_lut_timestamp_match #(
	parameter int TABLE_ROWS = 64,
	parameter int HOLD_ROWS  = 64,
	parameter int EVENT_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [5:0]  lut_index,
	input  logic [15:0] event_code,
	input  logic [31:0] entry_offset,
	input  logic [15:0] variable_id,
	input  logic [62:0] event_time,
	input  logic [62:0] window_start,
	input  logic [62:0] window_end,
	input  logic [20:0] samples_in_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [1:0]  status,
	output logic [62:0] delta_time,
	output logic [15:0] match_variable_id,
	output logic [62:0] match_time,
	output logic [19:0] sample_index,
	output logic [5:0]  hold_slot,
	output logic [6:0]  accepted_count,
	output logic [15:0] not_in_buffer_count,
	output logic        last
);
	import elt_pkg::*;

	localparam int AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
	localparam int TW = $clog2(HOLD_ROWS + 1);
	localparam int RW = $clog2(EVENT_ROWS + 1);
	localparam logic [AW-1:0] LAST_ROW = AW'(TABLE_ROWS - 1);

	state_t state_q, state_nx;

	logic [63:0] mem_q [TABLE_ROWS];
	logic [63:0] rd_data_q;
	logic [AW-1:0] rd_addr;

	logic [31:0] dead_q;
	logic [15:0] end_code_q;
	logic [62:0] ws_q, we_q, wt_q;
	logic [20:0] sam_q;
	logic        win_valid_q, done_q, ovf_q;
	logic [TW-1:0] taken_q;
	logic [15:0] misses_q;
	logic [RW-1:0] rows_q;
	logic [AW-1:0] i_q;
	logic [6:0]  n_q;
	logic [15:0] row_code_q;
	logic [62:0] row_time_q;
	logic [63:0] mt_q, b_q;
	logic [15:0] var_q;

	logic        pend_v_q;
	logic [15:0] pend_var_q;
	logic [62:0] pend_time_q, pend_delta_q;
	logic [19:0] pend_idx_q;
	logic [5:0]  pend_slot_q;
	logic [6:0]  pend_acc_q;
	logic [15:0] pend_miss_q;

	logic        out_valid_q, last_q;
	logic [1:0]  kind_q, status_q;
	logic [62:0] delta_q, time_q;
	logic [15:0] ovar_q, omiss_q;
	logic [19:0] oidx_q;
	logic [5:0]  oslot_q;
	logic [6:0]  oacc_q;

	logic        accept, out_free, wr_ok, out_load;
	logic [15:0] code_c, var_c;
	logic [31:0] off_c;
	logic        chk_stop, chk_hit, last_i, miss, full, flat, div_start, div_done;
	logic [20:0] div_q, cap, sidx;
	logic        late, early;
	logic [1:0]  win_st;
	logic [62:0] win_delta;
	logic [6:0]  acc_now, acc_next;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign wr_ok    = (32'(lut_index) < TABLE_ROWS);
	assign code_c   = rd_data_q[63:48];
	assign off_c    = rd_data_q[47:16];
	assign var_c    = rd_data_q[15:0];
	assign chk_stop = (code_c == end_code_q) || (code_c > row_code_q);
	assign chk_hit  = (code_c == row_code_q);
	assign last_i   = (i_q == LAST_ROW);
	assign miss     = (mt_q < {1'b0, ws_q}) || (mt_q > {1'b0, we_q});
	assign full     = (32'(taken_q) >= HOLD_ROWS) || (32'(n_q) >= OUT_LIMIT);
	assign flat     = (ws_q == we_q);

	always_comb begin
		late  = ({1'b0, wt_q} + {32'd0, dead_q}) < {1'b0, ws_q};
		early = {1'b0, wt_q} > ({1'b0, we_q} + {32'd0, dead_q});
		if (late) begin
			win_st    = ST_LATE;
			win_delta = ws_q - wt_q;
		end else if (early) begin
			win_st    = ST_EARLY;
			win_delta = wt_q - we_q;
		end else begin
			win_st    = ST_OK;
			win_delta = (wt_q >= ws_q) ? (wt_q - ws_q) : (ws_q - wt_q);
		end
	end

	always_comb begin
		cap = (sam_q == 21'd0) ? 21'd0 : (sam_q - 21'd1);
		if (cap > IDX_MAX) begin
			cap = IDX_MAX;
		end
		if (flat) begin
			sidx = 21'd0;
		end else begin
			sidx = (div_q > cap) ? cap : div_q;
		end
		acc_now  = (32'(taken_q) > 32'(COUNT_MAX)) ? COUNT_MAX : 7'(taken_q);
		acc_next = (32'(taken_q) + 32'd1 > 32'(COUNT_MAX)) ? COUNT_MAX :
			7'(taken_q + TW'(1));
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_WINDOW) begin
						state_nx = S_WIN;
					end else if (req_type == REQ_EVENT && win_valid_q) begin
						if (done_q || event_code == end_code_q) begin
							state_nx = S_SUM;
						end else begin
							state_nx = S_RD;
						end
					end
				end
			end
			S_WIN, S_SUM: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			S_RD: state_nx = S_CHK;
			S_CHK: begin
				if (chk_stop) begin
					state_nx = S_END;
				end else if (chk_hit) begin
					state_nx = S_MATCH;
				end else if (last_i) begin
					state_nx = S_END;
				end
			end
			S_MATCH: begin
				if (miss || full) begin
					state_nx = last_i ? S_END : S_RD;
				end else if (flat) begin
					state_nx = S_PUSH;
				end else begin
					state_nx = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_nx = S_PUSH;
				end
			end
			S_PUSH: begin
				if (!pend_v_q || out_free) begin
					state_nx = last_i ? S_END : S_RD;
				end
			end
			S_END: begin
				if (!pend_v_q || out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		rd_addr   = (state_q == S_CHK) ? (i_q + AW'(1)) : i_q;
		div_start = (state_q == S_MATCH) && !miss && !full && !flat;
		out_load  = out_free && ((state_q == S_WIN) || (state_q == S_SUM) ||
			(pend_v_q && ((state_q == S_PUSH) || (state_q == S_END))));
	end

	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_WRITE && wr_ok) begin
			mem_q[AW'(lut_index)] <= {event_code, entry_offset, variable_id};
		end
		rd_data_q <= mem_q[rd_addr];
	end

	elt_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (sam_q),
		.b      (mt_q - {1'b0, ws_q}),
		.c      ({1'b0, we_q} - {1'b0, ws_q}),
		.done   (div_done),
		.q      (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q      <= 32'd80000;
			end_code_q  <= 16'd99;
			ws_q        <= '0;
			we_q        <= '0;
			sam_q       <= 21'd1;
			win_valid_q <= 1'b0;
			done_q      <= 1'b0;
			ovf_q       <= 1'b0;
			taken_q     <= '0;
			misses_q    <= '0;
			rows_q      <= '0;
			i_q         <= '0;
			n_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DEAD_BAND: dead_q <= cfg_data;
					CFG_END_CODE:  end_code_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && req_type == REQ_WINDOW) begin
						ws_q     <= window_start;
						we_q     <= window_end;
						sam_q    <= samples_in_buffer;
						wt_q     <= event_time;
						taken_q  <= '0;
						misses_q <= '0;
						ovf_q    <= 1'b0;
						done_q   <= 1'b0;
						rows_q   <= '0;
					end
					if (accept && req_type == REQ_EVENT) begin
						row_code_q <= event_code;
						row_time_q <= event_time;
						i_q        <= '0;
						n_q        <= '0;
						if (win_valid_q && event_code == end_code_q) begin
							done_q <= 1'b1;
						end
					end
				end
				S_WIN: begin
					if (out_free) begin
						kind_q      <= KIND_WINDOW;
						status_q    <= win_st;
						delta_q     <= win_delta;
						ovar_q      <= '0;
						time_q      <= '0;
						oidx_q      <= '0;
						oslot_q     <= '0;
						oacc_q      <= '0;
						omiss_q     <= '0;
						last_q      <= 1'b1;
						win_valid_q <= (win_st == ST_OK);
					end
				end
				S_SUM: begin
					if (out_free) begin
						kind_q      <= KIND_SUMMARY;
						status_q    <= ovf_q ? ST_FULL : ST_OK;
						delta_q     <= '0;
						ovar_q      <= '0;
						time_q      <= '0;
						oidx_q      <= '0;
						oslot_q     <= '0;
						oacc_q      <= acc_now;
						omiss_q     <= misses_q;
						last_q      <= 1'b1;
					end
				end
				S_CHK: begin
					if (!chk_stop && chk_hit) begin
						mt_q  <= {1'b0, row_time_q} + {32'd0, off_c};
						var_q <= var_c;
					end else if (!chk_stop && !last_i) begin
						i_q <= i_q + AW'(1);
					end
				end
				S_MATCH: begin
					b_q <= mt_q - {1'b0, ws_q};
					if (miss) begin
						if (misses_q != 16'hFFFF) begin
							misses_q <= misses_q + 16'd1;
						end
					end else if (full) begin
						ovf_q <= 1'b1;
					end
					if ((miss || full) && !last_i) begin
						i_q <= i_q + AW'(1);
					end
				end
				S_PUSH: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							kind_q      <= KIND_MATCH;
							status_q    <= ST_OK;
							delta_q     <= pend_delta_q;
							ovar_q      <= pend_var_q;
							time_q      <= pend_time_q;
							oidx_q      <= pend_idx_q;
							oslot_q     <= pend_slot_q;
							oacc_q      <= pend_acc_q;
							omiss_q     <= pend_miss_q;
							last_q      <= 1'b0;
						end
						pend_v_q     <= 1'b1;
						pend_var_q   <= var_q;
						pend_time_q  <= mt_q[62:0];
						pend_delta_q <= b_q[62:0];
						pend_idx_q   <= sidx[19:0];
						pend_slot_q  <= 6'(taken_q);
						pend_acc_q   <= acc_next;
						pend_miss_q  <= misses_q;
						taken_q      <= taken_q + TW'(1);
						n_q          <= n_q + 7'd1;
						if (!last_i) begin
							i_q <= i_q + AW'(1);
						end
					end
				end
				S_END: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							kind_q      <= KIND_MATCH;
							status_q    <= ST_OK;
							delta_q     <= pend_delta_q;
							ovar_q      <= pend_var_q;
							time_q      <= pend_time_q;
							oidx_q      <= pend_idx_q;
							oslot_q     <= pend_slot_q;
							oacc_q      <= pend_acc_q;
							omiss_q     <= pend_miss_q;
							last_q      <= 1'b1;
						end
						pend_v_q <= 1'b0;
						rows_q   <= rows_q + RW'(1);
						if (32'(rows_q) + 32'd1 >= EVENT_ROWS) begin
							done_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid           = out_valid_q;
	assign result_kind         = kind_q;
	assign status              = status_q;
	assign delta_time          = delta_q;
	assign match_variable_id   = ovar_q;
	assign match_time          = time_q;
	assign sample_index        = oidx_q;
	assign hold_slot           = oslot_q;
	assign accepted_count      = oacc_q;
	assign not_in_buffer_count = omiss_q;
	assign last                = last_q;

endmodule

// ----- hdl/elt_checker.sv -----
// Port-level checks for event_lut_timestamp_match, attached by bind.
// Uses elt_pkg.
module elt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [1:0]  status,
	input logic [62:0] match_time,
	input logic        last
);
	import elt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(result_kind) && $stable(match_time))
		else $error("result beat changed while stalled");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_WINDOW || result_kind == KIND_SUMMARY) |-> last)
		else $error("window or summary beat without last");

	a_match_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_MATCH |-> status == ST_OK)
		else $error("match beat with non-success status");

endmodule

bind event_lut_timestamp_match elt_checker u_elt_checker (.*);

// ----- tb/tb_event_lut_timestamp_match.sv -----
// Self-checking testbench for event_lut_timestamp_match: table writes, buffer windows
// and event rows with random beat gaps, checked against an in-bench predictor.
// Depends on elt_pkg and the event_lut_timestamp_match RTL.
`timescale 1ns / 1ps

module tb_event_lut_timestamp_match;
	import elt_pkg::*;

	localparam int ROWS = 64;
	localparam logic [62:0] ALL63 = {63{1'b1}};

	typedef struct {
		logic [1:0]  req;
		logic [5:0]  idx;
		logic [15:0] code;
		logic [31:0] off;
		logic [15:0] var_id;
		logic [62:0] t;
		logic [62:0] ws;
		logic [62:0] we;
		logic [20:0] ns;
	} req_item_t;

	typedef struct {
		logic [1:0]  kind;
		logic [1:0]  st;
		logic [62:0] delta;
		logic [15:0] var_id;
		logic [62:0] mt;
		logic [19:0] sidx;
		logic [5:0]  slot;
		logic [6:0]  acc;
		logic [15:0] miss;
		logic        last;
	} match_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = '0;
	logic [5:0] lut_index = '0;
	logic [15:0] event_code = '0;
	logic [31:0] entry_offset = '0;
	logic [15:0] variable_id = '0;
	logic [62:0] event_time = '0;
	logic [62:0] window_start = '0;
	logic [62:0] window_end = '0;
	logic [20:0] samples_in_buffer = 21'd1;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] result_kind;
	logic [1:0] status;
	logic [62:0] delta_time;
	logic [15:0] match_variable_id;
	logic [62:0] match_time;
	logic [19:0] sample_index;
	logic [5:0] hold_slot;
	logic [6:0] accepted_count;
	logic [15:0] not_in_buffer_count;
	logic last;

	event_lut_timestamp_match dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [15:0] lut_code [ROWS];
	logic [31:0] lut_off [ROWS];
	logic [15:0] lut_var [ROWS];
	logic [31:0] dead_band;
	logic [15:0] end_code;
	logic [62:0] buf_start, buf_end;
	logic [20:0] buf_samples;
	logic win_ok, list_closed, overflow;
	int taken, misses, rows_done;

	// generator side copy of table codes
	logic [15:0] gen_code [ROWS];

	req_item_t pending_items[$];
	match_result_t expected_results[$];
	int mismatches = 0;
	int send_idle = 0, recv_idle = 0;
	bit long_hold_arm = 0;
	bit hold_done = 0;
	int hold_left = 0;
	logic in_took = 1'b0;

	function automatic match_result_t blank_result(logic [1:0] kind);
		match_result_t r;
		r = '{kind, ST_OK, '0, '0, '0, '0, '0, '0, '0, 1'b0};
		r.acc = (taken > 127) ? COUNT_MAX : taken[6:0];
		r.miss = misses[15:0];
		return r;
	endfunction

	function automatic void push_summary();
		match_result_t r;
		r = blank_result(KIND_SUMMARY);
		r.st = overflow ? ST_FULL : ST_OK;
		r.last = 1'b1;
		expected_results.push_back(r);
	endfunction

	function automatic void predict_beat(req_item_t it);
		logic [63:0] t64, mt;
		logic [127:0] prod;
		logic [63:0] cap, sidx;
		match_result_t r;
		int n;
		t64 = {1'b0, it.t};
		n = 0;
		if (it.req == REQ_WRITE) begin
			lut_code[it.idx] = it.code;
			lut_off[it.idx] = it.off;
			lut_var[it.idx] = it.var_id;
			return;
		end
		if (it.req == REQ_WINDOW) begin
			buf_start = it.ws;
			buf_end = it.we;
			buf_samples = it.ns;
			taken = 0;
			misses = 0;
			overflow = 0;
			list_closed = 0;
			rows_done = 0;
			r = blank_result(KIND_WINDOW);
			if (t64 + dead_band < {1'b0, it.ws}) begin
				r.st = ST_LATE;
				r.delta = it.ws - it.t;
			end else if (t64 > {1'b0, it.we} + dead_band) begin
				r.st = ST_EARLY;
				r.delta = it.t - it.we;
			end else begin
				r.st = ST_OK;
				r.delta = (it.t >= it.ws) ? it.t - it.ws : it.ws - it.t;
			end
			win_ok = (r.st == ST_OK);
			r.last = 1'b1;
			expected_results.push_back(r);
			return;
		end
		if (it.req != REQ_EVENT || !win_ok) return;
		if (list_closed) begin
			push_summary();
			return;
		end
		if (it.code == end_code) begin
			list_closed = 1;
			push_summary();
			return;
		end
		for (int i = 0; i < ROWS; i++) begin
			if (lut_code[i] == end_code || lut_code[i] > it.code) break;
			if (lut_code[i] != it.code) continue;
			mt = t64 + lut_off[i];
			if (mt < {1'b0, buf_start} || mt > {1'b0, buf_end}) begin
				if (misses < 16'hFFFF) misses++;
				continue;
			end
			if (taken >= 64 || n >= OUT_LIMIT) begin
				overflow = 1;
				continue;
			end
			if (buf_end == buf_start) begin
				sidx = 0;
			end else begin
				prod = (128'(buf_samples) * 128'(mt - buf_start)) / 128'(buf_end - buf_start);
				sidx = prod[63:0];
			end
			cap = (buf_samples != 0) ? 64'(buf_samples) - 1 : 0;
			if (cap > 64'hFFFFF) cap = 64'hFFFFF;
			if (sidx > cap) sidx = cap;
			taken++;
			r = blank_result(KIND_MATCH);
			r.delta = mt - buf_start;
			r.var_id = lut_var[i];
			r.mt = mt[62:0];
			r.sidx = sidx[19:0];
			r.slot = 6'(taken - 1);
			expected_results.push_back(r);
			n++;
		end
		rows_done++;
		if (rows_done >= 64) list_closed = 1;
		if (n > 0) expected_results[$].last = 1'b1;
	endfunction

	// input acceptance, prediction and result checking
	always @(posedge clk) begin
		match_result_t e;
		req_item_t it;
		in_took <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			it = '{req_type, lut_index, event_code, entry_offset, variable_id,
				event_time, window_start, window_end, samples_in_buffer};
			predict_beat(it);
		end
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat kind=%0d", result_kind);
			end else begin
				e = expected_results.pop_front();
				if (result_kind !== e.kind || status !== e.st || delta_time !== e.delta ||
				    match_variable_id !== e.var_id || match_time !== e.mt ||
				    sample_index !== e.sidx || hold_slot !== e.slot ||
				    accepted_count !== e.acc || not_in_buffer_count !== e.miss ||
				    last !== e.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp: k=%0d s=%0d d=%0d v=%0d t=%0d i=%0d h=%0d a=%0d m=%0d l=%0d",
							e.kind, e.st, e.delta, e.var_id, e.mt, e.sidx, e.slot,
							e.acc, e.miss, e.last);
						$display("         got: k=%0d s=%0d d=%0d v=%0d t=%0d i=%0d h=%0d a=%0d m=%0d l=%0d",
							result_kind, status, delta_time, match_variable_id, match_time,
							sample_index, hold_slot, accepted_count, not_in_buffer_count, last);
					end
				end
			end
		end
	end

	// sender
	always @(negedge clk) begin
		req_item_t it;
		if (arst_n && (!in_valid || in_took)) begin
			if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
				it = pending_items.pop_front();
				req_type <= it.req;
				lut_index <= it.idx;
				event_code <= it.code;
				entry_offset <= it.off;
				variable_id <= it.var_id;
				event_time <= it.t;
				window_start <= it.ws;
				window_end <= it.we;
				samples_in_buffer <= it.ns;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (long_hold_arm && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 3000;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle);
		end
	end

	function automatic logic [62:0] rand63();
		return 63'({$urandom, $urandom});
	endfunction

	function automatic req_item_t mk(logic [1:0] req);
		req_item_t it;
		it = '{req, '0, '0, '0, '0, '0, '0, '0, 21'd1};
		return it;
	endfunction

	task automatic add_lut(int i, logic [15:0] code, logic [31:0] off, logic [15:0] v);
		req_item_t it;
		it = mk(REQ_WRITE);
		it.idx = 6'(i);
		it.code = code;
		it.off = off;
		it.var_id = v;
		gen_code[i] = code;
		pending_items.push_back(it);
	endtask

	task automatic add_window(logic [62:0] t, logic [62:0] ws, logic [62:0] we,
			logic [20:0] ns);
		req_item_t it;
		it = mk(REQ_WINDOW);
		it.t = t;
		it.ws = ws;
		it.we = we;
		it.ns = ns;
		pending_items.push_back(it);
	endtask

	task automatic add_row(logic [15:0] code, logic [62:0] t);
		req_item_t it;
		it = mk(REQ_EVENT);
		it.code = code;
		it.t = t;
		pending_items.push_back(it);
	endtask

	task automatic fill_table();
		int c;
		c = $urandom_range(0, 4);
		for (int i = 0; i < ROWS; i++) begin
			if ($urandom_range(0, 99) < 15) c = c + $urandom_range(1, 40);
			else c = c + $urandom_range(0, 1);
			add_lut(i, c[15:0], ($urandom_range(0, 9) == 0) ? $urandom :
				$urandom_range(0, 300000), 16'($urandom));
		end
	endtask

	task automatic random_phase(int count);
		logic [62:0] ws, we, t;
		logic [20:0] ns;
		int span, rows, sel;
		req_item_t it;
		while (count > 0) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				it = mk(2'($urandom_range(0, 3)));
				it.idx = 6'($urandom);
				it.code = 16'($urandom);
				it.off = $urandom;
				it.var_id = 16'($urandom);
				it.t = rand63();
				it.ws = rand63();
				it.we = rand63();
				it.ns = 21'($urandom);
				if (it.req == REQ_WRITE) begin
					it.code = gen_code[it.idx];
					it.off = $urandom_range(0, 300000);
				end
				pending_items.push_back(it);
				count--;
				continue;
			end
			span = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2000000);
			ws = rand63() >> $urandom_range(1, 40);
			we = ws + span;
			case ($urandom_range(0, 9))
				0: ns = 21'h1FFFFF;
				1: ns = 21'd1;
				2: ns = 21'($urandom);
				default: ns = $urandom_range(1, 5000);
			endcase
			sel = $urandom_range(0, 9);
			if (sel == 0) t = ws - dead_band - 1 - $urandom_range(0, 1000);
			else if (sel == 1) t = we + dead_band + 1 + $urandom_range(0, 1000);
			else t = ws + $urandom_range(0, span);
			add_window(t, ws, we, ns);
			count--;
			rows = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
			for (int k = 0; k < rows; k++) begin
				t = ws - $urandom_range(0, 300000) + $urandom_range(0, span + 300000);
				if ($urandom_range(0, 29) == 0) add_row(end_code, t);
				else if ($urandom_range(0, 9) == 0) add_row(16'($urandom), rand63());
				else add_row(gen_code[$urandom_range(0, ROWS - 1)], t);
				count--;
			end
		end
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_DEAD_BAND) dead_band = data;
		else end_code = data[15:0];
	endtask

	initial begin
		dead_band = 32'd80000;
		end_code = 16'd99;
		buf_start = '0;
		buf_end = '0;
		buf_samples = 21'd1;
		win_ok = 0;
		list_closed = 0;
		overflow = 0;
		taken = 0;
		misses = 0;
		rows_done = 0;
		send_idle = 22;
		recv_idle = 68;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		add_row(16'd5, 63'd100);
		fill_table();
		add_lut(0, 16'h0000, 32'h0, 16'hFFFF);
		add_lut(63, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
		add_window(63'd0, ALL63, ALL63, 21'd1);
		add_row(16'd0, 63'd1);
		add_window(ALL63, 63'd0, 63'd5, 21'd1);
		add_window(63'd1000, 63'd1000, 63'd1000, 21'd5);
		add_row(16'd0, 63'd1000);
		add_window(63'd0, 63'd0, 63'd1000000, 21'h1FFFFF);
		add_row(16'd0, 63'd1000000);
		add_row(16'd0, 63'd500000);
		add_row(16'd0, ALL63);
		add_row(16'hFFFF, ALL63);
		add_lut(10, 16'h0000, 32'h0, 16'hA5A5);
		add_row(16'd0, 63'd0);
		add_row(end_code, 63'd0);
		add_row(16'd0, 63'd0);
		pending_items.push_back(mk(REQ_SPARE));
		add_window(63'd500, 63'd0, 63'd1000000, 21'd1048576);
		for (int k = 0; k < 66; k++) add_row(16'd0, 63'd0);
		drain();

		random_phase(70);
		drain();
		write_cfg(CFG_DEAD_BAND, 32'd0);
		write_cfg(CFG_END_CODE, 32'd0);
		send_idle = 68;
		recv_idle = 22;
		fill_table();
		random_phase(70);
		drain();
		write_cfg(CFG_DEAD_BAND, 32'hFFFF_FFFF);
		write_cfg(CFG_END_CODE, 32'h0000_FFFF);
		send_idle = 0;
		recv_idle = 0;
		fill_table();
		random_phase(70);
		@(posedge clk);
		long_hold_arm = 1;
		drain();

		if (mismatches == 0 && expected_results.size() == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
